[hw/rtl/lbpa_pkg.sv]
// Shared types and constants for the LIFO block pool allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package lbpa_pkg;

    // Field widths of the request, response and configuration port
    localparam int BLK_W     = 10;
    localparam int CNT_W     = 11;
    localparam int CFG_W     = 11;
    localparam int TOT_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_LIMIT  = 2'd1;

    // Register values after reset
    localparam logic [CFG_W-1:0] INIT_COUNT_RST = 11'd0;
    localparam logic [CFG_W-1:0] GROW_LIMIT_RST = 11'd1024;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_DROPPED   = 2'd2
    } t_status;

endpackage

`default_nettype wire

[hw/rtl/lbpa_if.sv]
// Request and response channel interfaces of the block pool allocator.
// Depends on lbpa_pkg for payload types and widths.
`default_nettype none

interface lbpa_req_if
    import lbpa_pkg::*;
;
    logic             valid;
    logic             ready;
    t_op              op;
    logic [BLK_W-1:0] block_in;

    modport source (output valid, output op, output block_in, input ready);
    modport sink   (input valid, input op, input block_in, output ready);
endinterface

interface lbpa_rsp_if
    import lbpa_pkg::*;
;
    logic             valid;
    logic             ready;
    t_status          status;
    logic [BLK_W-1:0] block_out;
    logic [CNT_W-1:0] free_blocks;
    logic [CNT_W-1:0] total_blocks;
    logic [TOT_W-1:0] alloc_count;
    logic [TOT_W-1:0] free_count;

    modport source (
        output valid, output status, output block_out, output free_blocks,
        output total_blocks, output alloc_count, output free_count, input ready
    );
    modport sink (
        input valid, input status, input block_out, input free_blocks,
        input total_blocks, input alloc_count, input free_count, output ready
    );
endinterface

`default_nettype wire

[hw/rtl/lbpa_stack.sv]
// Storage of returned block numbers: one write port, one registered read port.
// Depends on lbpa_pkg for the block number width.
`default_nettype none

module lbpa_stack
    import lbpa_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [BLK_W-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [BLK_W-1:0]         o_rdata
);

    logic [BLK_W-1:0] r_mem [DEPTH];
    logic [BLK_W-1:0] r_rdata;

    // Write the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read the top entry; hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/lifo_block_pool_allocator.sv]
// LIFO block pool allocator: hands out and takes back fixed-size block numbers.
// Depends on lbpa_pkg, lbpa_if (channels) and lbpa_stack (returned-block store).
//
// Usage: a request on i_req carries op (allocate or free) and block_in. Each
// accepted request yields exactly one response on o_rsp with status, the
// granted block, the free and created block counts and both wrapping totals.
// Allocate pops the newest returned block; with none returned it takes the
// top of the fresh range, growing that range by up to GROW_CHUNK block
// numbers when it is empty and the limit allows. Free pushes block_in, or
// drops it when the pool already holds its depth. The response is registered
// and valid in the cycle after the request transaction. One request per cycle
// while responses are taken; the stack read goes straight into the response.
// When the receiver stalls, the response holds and i_req.ready stays low
// until it is taken; nothing is lost or repeated.
// Configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we only
// while idle. A write to the initial count or the growth limit restarts the
// pool: stack empty, totals zero, the initial count of blocks fresh. Other
// indexes are ignored. Reset (synchronous, active low) gives initial count 0
// and growth limit 1024 with an empty pool; the stack needs no clearing pass.
`default_nettype none

module lifo_block_pool_allocator
    import lbpa_pkg::*;
#(
    parameter int POOL_DEPTH = 1024,
    parameter int GROW_CHUNK = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    lbpa_req_if.sink                  i_req,
    lbpa_rsp_if.source                o_rsp
);

    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [LW-1:0] DEPTH_L  = LW'(POOL_DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(POOL_DEPTH);
    localparam logic [31:0]   CHUNK_32 = 32'(GROW_CHUNK);
    localparam logic [CW-1:0] CHUNK_C  = CW'(GROW_CHUNK);
    localparam logic [CW-1:0] ONE_C    = CW'(1);

    // Configuration and pool state
    logic [CFG_W-1:0] r_init_blocks;
    logic [CFG_W-1:0] r_grow_limit;
    logic [CW-1:0]    r_depth,   n_depth;
    logic [CW-1:0]    r_low,     n_low;
    logic [CW-1:0]    r_high,    n_high;
    logic [CW-1:0]    r_created, n_created;
    logic [TOT_W-1:0] r_alloc_total, n_alloc_total;
    logic [TOT_W-1:0] r_free_total,  n_free_total;

    // Response register
    logic             r_out_valid, n_out_valid;
    t_status          r_status,    n_status;
    logic             r_from_mem,  n_from_mem;
    logic [BLK_W-1:0] r_block,     n_block;

    logic             accept;
    logic             cfg_hit;
    logic [CFG_W-1:0] cfg_init;
    logic [CW-1:0]    init_lim;
    logic [CW-1:0]    lim;
    logic [CW-1:0]    room;
    logic [CW-1:0]    grow_n;
    logic [CW-1:0]    held;
    logic [CW-1:0]    depth_m1;
    logic [CW-1:0]    g_low;
    logic [CW-1:0]    g_high;
    logic             stk_we;
    logic             stk_re;
    logic [BLK_W-1:0] stk_rdata;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_valid || o_rsp.ready;

    // Saturate the limits at the pool depth
    assign lim = (LW'(r_grow_limit) > DEPTH_L) ? DEPTH_C : CW'(r_grow_limit);

    assign cfg_hit  = i_cfg_we &&
                      (i_cfg_idx == CFG_INIT_COUNT || i_cfg_idx == CFG_GROW_LIMIT);
    assign cfg_init = (i_cfg_idx == CFG_INIT_COUNT) ? i_cfg_data : r_init_blocks;
    assign init_lim = (LW'(cfg_init) > DEPTH_L) ? DEPTH_C : CW'(cfg_init);

    assign room     = lim - r_created;
    assign grow_n   = (32'(room) > CHUNK_32) ? CHUNK_C : room;
    assign held     = r_depth + (r_high - r_low);
    assign depth_m1 = r_depth - ONE_C;

    // Work out the next pool state and response for an accepted request
    always_comb begin
        n_depth       = r_depth;
        n_low         = r_low;
        n_high        = r_high;
        n_created     = r_created;
        n_alloc_total = r_alloc_total;
        n_free_total  = r_free_total;
        n_status      = ST_DONE;
        n_from_mem    = 1'b0;
        n_block       = '0;
        g_low         = r_low;
        g_high        = r_high;
        stk_we        = 1'b0;
        stk_re        = 1'b0;
        if (accept) begin
            unique case (i_req.op)
                OP_ALLOC: begin
                    // Grow the fresh range when nothing is free
                    if (r_depth == '0 && r_high == r_low && r_created < lim) begin
                        g_low     = r_created;
                        g_high    = r_created + grow_n;
                        n_created = r_created + grow_n;
                    end
                    n_low  = g_low;
                    n_high = g_high;
                    priority if (r_depth != '0) begin
                        n_depth       = depth_m1;
                        stk_re        = 1'b1;
                        n_from_mem    = 1'b1;
                        n_alloc_total = r_alloc_total + 1'b1;
                    end else if (g_high > g_low) begin
                        n_high        = g_high - ONE_C;
                        n_block       = BLK_W'(g_high - ONE_C);
                        n_alloc_total = r_alloc_total + 1'b1;
                    end else begin
                        n_status = ST_EXHAUSTED;
                    end
                end
                OP_FREE: begin
                    // Drop the push when the pool already holds its depth
                    if (held >= DEPTH_C) begin
                        n_status = ST_DROPPED;
                    end else begin
                        stk_we       = 1'b1;
                        n_depth      = r_depth + ONE_C;
                        n_free_total = r_free_total + 1'b1;
                    end
                end
            endcase
        end
        n_out_valid = accept ? 1'b1 : (o_rsp.ready ? 1'b0 : r_out_valid);
    end

    // Update configuration and pool state; a restart wins over a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_blocks <= INIT_COUNT_RST;
            r_grow_limit  <= GROW_LIMIT_RST;
            r_depth       <= '0;
            r_low         <= '0;
            r_high        <= '0;
            r_created     <= '0;
            r_alloc_total <= '0;
            r_free_total  <= '0;
            r_out_valid   <= 1'b0;
        end else if (cfg_hit) begin
            if (i_cfg_idx == CFG_INIT_COUNT) begin
                r_init_blocks <= i_cfg_data;
            end else begin
                r_grow_limit <= i_cfg_data;
            end
            r_depth       <= '0;
            r_low         <= '0;
            r_high        <= init_lim;
            r_created     <= init_lim;
            r_alloc_total <= '0;
            r_free_total  <= '0;
            r_out_valid   <= n_out_valid;
        end else begin
            r_depth       <= n_depth;
            r_low         <= n_low;
            r_high        <= n_high;
            r_created     <= n_created;
            r_alloc_total <= n_alloc_total;
            r_free_total  <= n_free_total;
            r_out_valid   <= n_out_valid;
        end
    end

    // Capture the response payload with each transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= n_status;
            r_from_mem <= n_from_mem;
            r_block    <= n_block;
        end
    end

    lbpa_stack #(
        .DEPTH (POOL_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (i_req.block_in),
        .i_re    (stk_re),
        .i_raddr (depth_m1[AW-1:0]),
        .o_rdata (stk_rdata)
    );

    // Drive the response; counts follow the state, which moves only with a transaction or a restart
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.block_out    = r_from_mem ? stk_rdata : r_block;
    assign o_rsp.free_blocks  = CNT_W'(held);
    assign o_rsp.total_blocks = CNT_W'(r_created);
    assign o_rsp.alloc_count  = r_alloc_total;
    assign o_rsp.free_count   = r_free_total;

    // Free plus fresh blocks never exceed the pool depth
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_depth) + 32'(r_high - r_low)) <= 32'(POOL_DEPTH))
        else $error("pool holds more blocks than its depth");

    // The fresh range stays ordered and at or below the created count
    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_low <= r_high) && (r_high <= r_created))
        else $error("fresh range out of order");

    // A stalled response blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !accept)
        else $error("request taken while response stalled");

    // A stalled popped block keeps its read data
    a_pop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready && r_from_mem) |=> $stable(stk_rdata))
        else $error("popped block changed while stalled");

endmodule

`default_nettype wire
